// ===== sv/rls_pkg.sv =====
`default_nettype none

package rls_pkg;

    // Default array size and right-hand-side block width
    localparam int MATRIX_SIZE  = 16;
    localparam int RHS_COLUMNS  = 4;

    // Widest index fields carried on the command bus
    localparam int IDX_W        = 6;
    localparam int CIDX_W       = 4;

    localparam int CHECK_PERIOD = 5;
    localparam int DIV_STEPS    = 33;

    localparam int LIMIT_W      = 8;
    localparam int TOL_W        = 31;
    localparam int CFG_W        = 31;
    localparam int CFG_IDX_W    = 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd15;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 1'b1;

    localparam logic [1:0] MODE_A     = 2'd0;
    localparam logic [1:0] MODE_B     = 2'd1;
    localparam logic [1:0] MODE_SOLVE = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_START,
        OP_NORM_RD,
        OP_NORM_ACC,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_INIT_RD,
        OP_INIT_MUL,
        OP_INIT_WB,
        OP_RES_BRD,
        OP_RES_BLD,
        OP_RES_RD,
        OP_RES_MUL,
        OP_RES_ACC,
        OP_RES_WB,
        OP_UPD_RD,
        OP_UPD_MUL,
        OP_UPD_WB,
        OP_CONV,
        OP_OUT_RD,
        OP_OUT_LD
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [IDX_W-1:0]  r;
        logic [IDX_W-1:0]  k;
        logic [CIDX_W-1:0] c;
        logic              first;
        logic              last;
    } dp_cmd_t;

    typedef struct packed {
        logic peak_below;
        logic out_taken;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/rls_ram.sv =====
`default_nettype none

module rls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/rls_dp.sv =====
`default_nettype none

module rls_dp #(
    parameter int MATRIX_SIZE = rls_pkg::MATRIX_SIZE,
    parameter int RHS_COLUMNS = rls_pkg::RHS_COLUMNS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rls_pkg::dp_cmd_t                  cmd,
    output rls_pkg::dp_sts_t                       sts,
    input  wire logic                              cfg_wen,
    input  wire logic [rls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rls_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic [1:0]                        mode,
    input  wire logic [3:0]                        row,
    input  wire logic [3:0]                        col,
    input  wire logic signed [31:0]                value,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [3:0]                             row_res,
    output logic [3:0]                             col_res,
    output logic signed [31:0]                     solution,
    output logic                                   converged,
    output logic                                   saturated,
    output logic                                   last
);

    localparam int NW      = $clog2(MATRIX_SIZE);
    localparam int CW      = (RHS_COLUMNS > 1) ? $clog2(RHS_COLUMNS) : 1;
    localparam int A_DEPTH = MATRIX_SIZE * MATRIX_SIZE;
    localparam int X_DEPTH = MATRIX_SIZE * RHS_COLUMNS;
    localparam int AAW     = $clog2(A_DEPTH);
    localparam int XAW     = $clog2(X_DEPTH);

    localparam logic signed [31:0] Q_MAX32 = 32'sh7FFF_FFFF;

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] res;
        if (v > 64'sd2147483647)
        begin
            res = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < -64'sd2147483648)
        begin
            res = {1'b1, 32'h8000_0000};
        end
        else
        begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

    // Memory ports
    logic               a_we, b_we, x_we, r_we;
    logic               a_re, b_re, x_re, r_re;
    logic [AAW-1:0]     a_waddr, a_raddr;
    logic [XAW-1:0]     b_waddr, rc_addr, kc_addr, x_raddr;
    logic signed [31:0] a_rd, b_rd, x_rd, r_rd;
    logic signed [31:0] x_wdata, r_wdata;

    // Arithmetic state
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_full;
    logic signed [63:0] rnd_full;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] acc_reg, acc_next;
    logic [30:0]        rowsum_reg, rowsum_next;
    logic [30:0]        norm_reg, norm_next;
    logic [30:0]        dvs_reg, dvs_next;
    logic [32:0]        rem_reg, rem_next;
    logic [32:0]        quo_reg, quo_next;
    logic signed [31:0] omega_reg, omega_next;
    logic [31:0]        peak_reg, peak_next;
    logic [rls_pkg::TOL_W-1:0] tol_reg;
    logic               flag_reg, conv_reg;
    logic               sat_hit;

    logic               out_valid_reg;
    logic [3:0]         row_res_reg, col_res_reg;
    logic signed [31:0] solution_reg;
    logic               conv_out_reg, sat_out_reg, last_reg;

    logic [30:0]        a_abs;
    logic               a_abs_ovf;
    logic [31:0]        rs_sum;
    logic [32:0]        init_sat, res_sat, upd_sat;
    logic [31:0]        res_mag;
    logic [32:0]        div_sh;

    // Address generation
    assign a_waddr = AAW'(int'(row) * MATRIX_SIZE + int'(col));
    assign b_waddr = XAW'(int'(row) * RHS_COLUMNS + int'(col));
    assign a_raddr = AAW'(int'(cmd.r[NW-1:0]) * MATRIX_SIZE + int'(cmd.k[NW-1:0]));
    assign rc_addr = XAW'(int'(cmd.r[NW-1:0]) * RHS_COLUMNS + int'(cmd.c[CW-1:0]));
    assign kc_addr = XAW'(int'(cmd.k[NW-1:0]) * RHS_COLUMNS + int'(cmd.c[CW-1:0]));

    assign a_we = (cmd.op == rls_pkg::OP_LOAD) && (mode == rls_pkg::MODE_A)
                  && (int'(row) < MATRIX_SIZE) && (int'(col) < MATRIX_SIZE);
    assign b_we = (cmd.op == rls_pkg::OP_LOAD) && (mode == rls_pkg::MODE_B)
                  && (int'(row) < MATRIX_SIZE) && (int'(col) < RHS_COLUMNS);
    assign a_re = (cmd.op == rls_pkg::OP_NORM_RD) || (cmd.op == rls_pkg::OP_RES_RD);
    assign b_re = (cmd.op == rls_pkg::OP_INIT_RD) || (cmd.op == rls_pkg::OP_RES_BRD);
    assign x_we = (cmd.op == rls_pkg::OP_INIT_WB) || (cmd.op == rls_pkg::OP_UPD_WB);
    assign x_re = (cmd.op == rls_pkg::OP_RES_RD) || (cmd.op == rls_pkg::OP_UPD_RD)
                  || (cmd.op == rls_pkg::OP_OUT_RD);
    assign x_raddr = (cmd.op == rls_pkg::OP_RES_RD) ? kc_addr : rc_addr;
    assign r_we = (cmd.op == rls_pkg::OP_RES_WB);
    assign r_re = (cmd.op == rls_pkg::OP_UPD_RD);

    rls_ram #(.WIDTH(32), .DEPTH(A_DEPTH)) u_a_ram (
        .clk     (clk),
        .wr_en   (a_we),
        .wr_addr (a_waddr),
        .wr_data (value),
        .rd_en   (a_re),
        .rd_addr (a_raddr),
        .rd_data (a_rd)
    );

    rls_ram #(.WIDTH(32), .DEPTH(X_DEPTH)) u_b_ram (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (value),
        .rd_en   (b_re),
        .rd_addr (rc_addr),
        .rd_data (b_rd)
    );

    rls_ram #(.WIDTH(32), .DEPTH(X_DEPTH)) u_x_ram (
        .clk     (clk),
        .wr_en   (x_we),
        .wr_addr (rc_addr),
        .wr_data (x_wdata),
        .rd_en   (x_re),
        .rd_addr (x_raddr),
        .rd_data (x_rd)
    );

    rls_ram #(.WIDTH(32), .DEPTH(X_DEPTH)) u_r_ram (
        .clk     (clk),
        .wr_en   (r_we),
        .wr_addr (rc_addr),
        .wr_data (r_wdata),
        .rd_en   (r_re),
        .rd_addr (rc_addr),
        .rd_data (r_rd)
    );

    // Shared multiplier and rounding
    always_comb
    begin
        case (cmd.op)
            rls_pkg::OP_INIT_MUL:
            begin
                mul_a = omega_reg;
                mul_b = b_rd;
            end
            rls_pkg::OP_UPD_MUL:
            begin
                mul_a = omega_reg;
                mul_b = r_rd;
            end
            default:
            begin
                mul_a = a_rd;
                mul_b = x_rd;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign rnd_full  = (prod_reg + 64'sd32768) >>> 16;

    assign init_sat = sat32(rnd_full);
    assign res_sat  = sat32(acc_reg);
    assign upd_sat  = sat32(64'(x_rd) + rnd_full);
    assign x_wdata  = (cmd.op == rls_pkg::OP_INIT_WB) ? init_sat[31:0] : upd_sat[31:0];
    assign r_wdata  = res_sat[31:0];
    assign res_mag  = res_sat[31] ? (~res_sat[31:0] + 32'd1) : res_sat[31:0];

    // Absolute value and saturating row sum
    always_comb
    begin
        a_abs_ovf = 1'b0;
        if (a_rd[31])
        begin
            if (a_rd == -Q_MAX32 - 32'sd1)
            begin
                a_abs     = 31'h7FFF_FFFF;
                a_abs_ovf = 1'b1;
            end
            else
            begin
                a_abs = 31'(-a_rd);
            end
        end
        else
        begin
            a_abs = a_rd[30:0];
        end
    end

    assign rs_sum = {1'b0, (cmd.first ? 31'd0 : rowsum_reg)} + {1'b0, a_abs};
    assign div_sh = {rem_reg[31:0], cmd.first};

    always_comb
    begin
        rowsum_next = rowsum_reg;
        norm_next   = norm_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        omega_next  = omega_reg;
        acc_next    = acc_reg;
        peak_next   = peak_reg;
        sat_hit     = 1'b0;
        case (cmd.op)
            rls_pkg::OP_START:
            begin
                norm_next = 31'd0;
            end
            rls_pkg::OP_NORM_ACC:
            begin
                sat_hit = a_abs_ovf | rs_sum[31];
                rowsum_next = rs_sum[31] ? 31'h7FFF_FFFF : rs_sum[30:0];
                if (cmd.last && (rowsum_next > norm_reg))
                begin
                    norm_next = rowsum_next;
                end
            end
            rls_pkg::OP_DIV_START:
            begin
                dvs_next = (norm_reg == 31'd0) ? 31'd1 : norm_reg;
                rem_next = 33'd0;
                quo_next = 33'd0;
            end
            rls_pkg::OP_DIV_STEP:
            begin
                if (div_sh >= {2'b00, dvs_reg})
                begin
                    rem_next = div_sh - {2'b00, dvs_reg};
                    quo_next = {quo_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_next = div_sh;
                    quo_next = {quo_reg[31:0], 1'b0};
                end
            end
            rls_pkg::OP_DIV_END:
            begin
                if (quo_reg > 33'h0_7FFF_FFFF)
                begin
                    omega_next = Q_MAX32;
                    sat_hit    = 1'b1;
                end
                else
                begin
                    omega_next = quo_reg[31:0];
                end
            end
            rls_pkg::OP_INIT_WB:
            begin
                sat_hit = init_sat[32];
            end
            rls_pkg::OP_RES_BRD:
            begin
                if (cmd.first)
                begin
                    peak_next = 32'd0;
                end
            end
            rls_pkg::OP_RES_BLD:
            begin
                acc_next = 64'(b_rd);
            end
            rls_pkg::OP_RES_ACC:
            begin
                acc_next = acc_reg - rnd_full;
            end
            rls_pkg::OP_RES_WB:
            begin
                sat_hit = res_sat[32];
                if (res_mag > peak_reg)
                begin
                    peak_next = res_mag;
                end
            end
            rls_pkg::OP_UPD_WB:
            begin
                sat_hit = upd_sat[32];
            end
            default:
            begin
            end
        endcase
    end

    // Control and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= rls_pkg::TOL_RESET;
            flag_reg      <= 1'b0;
            conv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            omega_reg     <= 32'sd0;
        end
        else
        begin
            if (cfg_wen && (cfg_index == rls_pkg::CFG_TOL))
            begin
                tol_reg <= cfg_data[rls_pkg::TOL_W-1:0];
            end
            if (cmd.op == rls_pkg::OP_START)
            begin
                flag_reg <= 1'b0;
                conv_reg <= 1'b0;
            end
            else
            begin
                flag_reg <= flag_reg | sat_hit;
                if (cmd.op == rls_pkg::OP_CONV)
                begin
                    conv_reg <= 1'b1;
                end
            end
            omega_reg <= omega_next;
            if (cmd.op == rls_pkg::OP_OUT_LD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rowsum_reg <= rowsum_next;
        norm_reg   <= norm_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        acc_reg    <= acc_next;
        peak_reg   <= peak_next;
        if ((cmd.op == rls_pkg::OP_INIT_MUL) || (cmd.op == rls_pkg::OP_RES_MUL)
            || (cmd.op == rls_pkg::OP_UPD_MUL))
        begin
            prod_reg <= prod_full;
        end
        if (cmd.op == rls_pkg::OP_OUT_LD)
        begin
            solution_reg <= x_rd;
            row_res_reg  <= cmd.r[3:0];
            col_res_reg  <= cmd.c[3:0];
            conv_out_reg <= conv_reg;
            sat_out_reg  <= flag_reg;
            last_reg     <= cmd.last;
        end
    end

    assign sts.peak_below = (peak_reg < {1'b0, tol_reg});
    assign sts.out_taken  = out_valid_reg && out_ready;

    assign out_valid = out_valid_reg;
    assign row_res   = row_res_reg;
    assign col_res   = col_res_reg;
    assign solution  = solution_reg;
    assign converged = conv_out_reg;
    assign saturated = sat_out_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== sv/rls_ctrl.sv =====
`default_nettype none

module rls_ctrl #(
    parameter int MATRIX_SIZE = rls_pkg::MATRIX_SIZE,
    parameter int RHS_COLUMNS = rls_pkg::RHS_COLUMNS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    mode,
    input  wire logic                          cfg_wen,
    input  wire logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rls_pkg::CFG_W-1:0]     cfg_data,
    input  wire rls_pkg::dp_sts_t              sts,
    output rls_pkg::dp_cmd_t                   cmd
);

    localparam int NW  = $clog2(MATRIX_SIZE);
    localparam int CW  = (RHS_COLUMNS > 1) ? $clog2(RHS_COLUMNS) : 1;
    localparam int DCW = $clog2(rls_pkg::DIV_STEPS);

    typedef enum logic [21:0] {
        S_IDLE     = 22'h000001,
        S_NORM_RD  = 22'h000002,
        S_NORM_ACC = 22'h000004,
        S_DIV_ST   = 22'h000008,
        S_DIV_STEP = 22'h000010,
        S_DIV_END  = 22'h000020,
        S_INIT_RD  = 22'h000040,
        S_INIT_MUL = 22'h000080,
        S_INIT_WB  = 22'h000100,
        S_RES_BRD  = 22'h000200,
        S_RES_BLD  = 22'h000400,
        S_RES_RD   = 22'h000800,
        S_RES_MUL  = 22'h001000,
        S_RES_ACC  = 22'h002000,
        S_RES_WB   = 22'h004000,
        S_UPD_RD   = 22'h008000,
        S_UPD_MUL  = 22'h010000,
        S_UPD_WB   = 22'h020000,
        S_CHECK    = 22'h040000,
        S_OUT_RD   = 22'h080000,
        S_OUT_LD   = 22'h100000,
        S_OUT_WAIT = 22'h200000
    } state_t;

    state_t                       state_reg, state_next;
    logic [NW-1:0]                r_reg, r_next;
    logic [NW-1:0]                k_reg, k_next;
    logic [CW-1:0]                c_reg, c_next;
    logic [DCW-1:0]               div_reg, div_next;
    logic [rls_pkg::LIMIT_W-1:0]  limit_reg;
    logic [rls_pkg::LIMIT_W-1:0]  done_reg, done_next, done_inc;
    logic [2:0]                   batch_reg, batch_next, batch_inc;
    logic                         pass0_reg, pass0_next;
    logic                         last_r, last_c, last_k, rc_end;
    logic [NW-1:0]                r_adv;
    logic [CW-1:0]                c_adv;

    assign last_r = (r_reg == NW'(MATRIX_SIZE - 1));
    assign last_k = (k_reg == NW'(MATRIX_SIZE - 1));
    assign last_c = (c_reg == CW'(RHS_COLUMNS - 1));
    assign rc_end = last_r && last_c;
    // Row-major walk over the solution block: column fastest
    assign c_adv  = last_c ? '0 : c_reg + CW'(1);
    assign r_adv  = last_c ? (last_r ? '0 : r_reg + NW'(1)) : r_reg;
    assign done_inc  = done_reg + 8'd1;
    assign batch_inc = batch_reg + 3'd1;

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        div_next   = div_reg;
        done_next  = done_reg;
        batch_next = batch_reg;
        pass0_next = pass0_reg;
        in_ready   = 1'b0;
        cmd.op     = rls_pkg::OP_NOP;
        cmd.r      = rls_pkg::IDX_W'(r_reg);
        cmd.k      = rls_pkg::IDX_W'(k_reg);
        cmd.c      = rls_pkg::CIDX_W'(c_reg);
        cmd.first  = 1'b0;
        cmd.last   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode == rls_pkg::MODE_SOLVE)
                    begin
                        cmd.op     = rls_pkg::OP_START;
                        r_next     = '0;
                        k_next     = '0;
                        c_next     = '0;
                        state_next = S_NORM_RD;
                    end
                    else
                    begin
                        cmd.op = rls_pkg::OP_LOAD;
                    end
                end
            end
            S_NORM_RD:
            begin
                cmd.op     = rls_pkg::OP_NORM_RD;
                state_next = S_NORM_ACC;
            end
            S_NORM_ACC:
            begin
                cmd.op    = rls_pkg::OP_NORM_ACC;
                cmd.first = (k_reg == '0);
                cmd.last  = last_k;
                if (last_k)
                begin
                    k_next = '0;
                    if (last_r)
                    begin
                        r_next     = '0;
                        state_next = S_DIV_ST;
                    end
                    else
                    begin
                        r_next     = r_reg + NW'(1);
                        state_next = S_NORM_RD;
                    end
                end
                else
                begin
                    k_next     = k_reg + NW'(1);
                    state_next = S_NORM_RD;
                end
            end
            S_DIV_ST:
            begin
                cmd.op     = rls_pkg::OP_DIV_START;
                div_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                // The only set bit of the dividend enters on the first step
                cmd.op    = rls_pkg::OP_DIV_STEP;
                cmd.first = (div_reg == '0);
                if (div_reg == DCW'(rls_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DIV_END;
                end
                else
                begin
                    div_next = div_reg + DCW'(1);
                end
            end
            S_DIV_END:
            begin
                cmd.op     = rls_pkg::OP_DIV_END;
                state_next = S_INIT_RD;
            end
            S_INIT_RD:
            begin
                cmd.op     = rls_pkg::OP_INIT_RD;
                state_next = S_INIT_MUL;
            end
            S_INIT_MUL:
            begin
                cmd.op     = rls_pkg::OP_INIT_MUL;
                state_next = S_INIT_WB;
            end
            S_INIT_WB:
            begin
                cmd.op = rls_pkg::OP_INIT_WB;
                r_next = r_adv;
                c_next = c_adv;
                if (rc_end)
                begin
                    pass0_next = 1'b1;
                    state_next = S_RES_BRD;
                end
                else
                begin
                    state_next = S_INIT_RD;
                end
            end
            S_RES_BRD:
            begin
                cmd.op     = rls_pkg::OP_RES_BRD;
                cmd.first  = (r_reg == '0) && (c_reg == '0);
                state_next = S_RES_BLD;
            end
            S_RES_BLD:
            begin
                cmd.op     = rls_pkg::OP_RES_BLD;
                k_next     = '0;
                state_next = S_RES_RD;
            end
            S_RES_RD:
            begin
                cmd.op     = rls_pkg::OP_RES_RD;
                state_next = S_RES_MUL;
            end
            S_RES_MUL:
            begin
                cmd.op     = rls_pkg::OP_RES_MUL;
                state_next = S_RES_ACC;
            end
            S_RES_ACC:
            begin
                cmd.op = rls_pkg::OP_RES_ACC;
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = S_RES_WB;
                end
                else
                begin
                    k_next     = k_reg + NW'(1);
                    state_next = S_RES_RD;
                end
            end
            S_RES_WB:
            begin
                cmd.op = rls_pkg::OP_RES_WB;
                r_next = r_adv;
                c_next = c_adv;
                if (rc_end)
                begin
                    if (pass0_reg)
                    begin
                        pass0_next = 1'b0;
                        done_next  = '0;
                        batch_next = '0;
                        state_next = (limit_reg == '0) ? S_OUT_RD : S_UPD_RD;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    state_next = S_RES_BRD;
                end
            end
            S_UPD_RD:
            begin
                cmd.op     = rls_pkg::OP_UPD_RD;
                state_next = S_UPD_MUL;
            end
            S_UPD_MUL:
            begin
                cmd.op     = rls_pkg::OP_UPD_MUL;
                state_next = S_UPD_WB;
            end
            S_UPD_WB:
            begin
                cmd.op = rls_pkg::OP_UPD_WB;
                r_next = r_adv;
                c_next = c_adv;
                state_next = rc_end ? S_RES_BRD : S_UPD_RD;
            end
            S_CHECK:
            begin
                // Count the update just finished; test residual at batch end or limit
                done_next = done_inc;
                if ((batch_inc == 3'(rls_pkg::CHECK_PERIOD)) || (done_inc == limit_reg))
                begin
                    batch_next = '0;
                    if (sts.peak_below)
                    begin
                        cmd.op     = rls_pkg::OP_CONV;
                        state_next = S_OUT_RD;
                    end
                    else if (done_inc == limit_reg)
                    begin
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        state_next = S_UPD_RD;
                    end
                end
                else
                begin
                    batch_next = batch_inc;
                    state_next = S_UPD_RD;
                end
            end
            S_OUT_RD:
            begin
                cmd.op     = rls_pkg::OP_OUT_RD;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.op     = rls_pkg::OP_OUT_LD;
                cmd.last   = rc_end;
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (sts.out_taken)
                begin
                    r_next = r_adv;
                    c_next = c_adv;
                    state_next = rc_end ? S_IDLE : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            r_reg     <= '0;
            k_reg     <= '0;
            c_reg     <= '0;
            div_reg   <= '0;
            done_reg  <= '0;
            batch_reg <= '0;
            pass0_reg <= 1'b0;
            limit_reg <= rls_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            div_reg   <= div_next;
            done_reg  <= done_next;
            batch_reg <= batch_next;
            pass0_reg <= pass0_next;
            if (cfg_wen && (cfg_index == rls_pkg::CFG_LIMIT))
            begin
                limit_reg <= cfg_data[rls_pkg::LIMIT_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/richardson_linear_solver.sv =====
`default_nettype none

// Richardson iteration solver for A X = B in signed Q16.16.
// Input channel (in_valid/in_ready): each beat carries mode, row, col, value.
//   Mode A and mode B beats each write one matrix or right-hand-side entry;
//   writes with an index past the stored size are dropped.
//   A solve beat (mode 2) starts the run; in_ready stays low until the last
//   solution beat has been taken. Mode 3 beats are accepted and dropped.
// Output channel (out_valid/out_ready): MATRIX_SIZE*RHS_COLUMNS beats, row by
//   row, rhs column fastest, with last high on the final beat.
// Configuration: cfg_wen writes iteration_limit (index 0) or tolerance
//   (index 1) from cfg_data; write only while the block is idle.
// Steps, all through one multiplier and single-port memory reads: row-norm
// sweep, step-factor division, start vector and a residual pass, then update
// passes, each followed by a residual pass and a check step. Results leave
// one beat at a time, the next beat read only after the current one is taken;
// a low out_ready holds the current beat and stalls the sequencer. Reset
// drops any run in flight, returns to idle, and restores iteration_limit 15
// and tolerance 1. The stores need no clearing after reset.
module richardson_linear_solver #(
    parameter int MATRIX_SIZE = rls_pkg::MATRIX_SIZE,
    parameter int RHS_COLUMNS = rls_pkg::RHS_COLUMNS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    mode,
    input  wire logic [3:0]                    row,
    input  wire logic [3:0]                    col,
    input  wire logic signed [31:0]            value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [3:0]                         row_res,
    output logic [3:0]                         col_res,
    output logic signed [31:0]                 solution,
    output logic                               converged,
    output logic                               saturated,
    output logic                               last,
    input  wire logic                          cfg_wen,
    input  wire logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rls_pkg::CFG_W-1:0]     cfg_data
);

    // Command bus from sequencer to datapath, status back
    rls_pkg::dp_cmd_t cmd;
    rls_pkg::dp_sts_t sts;

    rls_ctrl #(
        .MATRIX_SIZE (MATRIX_SIZE),
        .RHS_COLUMNS (RHS_COLUMNS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .cmd       (cmd)
    );

    rls_dp #(
        .MATRIX_SIZE (MATRIX_SIZE),
        .RHS_COLUMNS (RHS_COLUMNS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .row_res   (row_res),
        .col_res   (col_res),
        .solution  (solution),
        .converged (converged),
        .saturated (saturated),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== sv/rls_checker.sv =====
`default_nettype none

module rls_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  mode,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] solution,
    input wire logic        last
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(solution) && $stable(last))
        else $error("result beat changed while stalled");

    // Never take input while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // A solve beat closes the input side
    a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (mode == rls_pkg::MODE_SOLVE) |=> !in_ready)
        else $error("input ready right after solve");

    // Mid-stream the input side stays closed
    a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> !in_ready)
        else $error("input ready before last beat");

endmodule

bind richardson_linear_solver rls_checker u_rls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .solution  (solution),
    .last      (last)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int N_ROWS      = 16;
    localparam int N_COLS      = 4;
    localparam int N_ENTRIES   = N_ROWS * N_COLS;
    localparam int STALL_LIMIT = 3000000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         mode;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } load_beat_t;

    typedef struct {
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] x;
        logic               conv;
        logic               sat;
        logic               last;
    } sol_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         mode = '0;
    logic [3:0]         row = '0;
    logic [3:0]         col = '0;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         row_res;
    logic [3:0]         col_res;
    logic signed [31:0] solution;
    logic               converged;
    logic               saturated;
    logic               last;
    logic               cfg_wen = 1'b0;
    logic [rls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rls_pkg::CFG_W-1:0]     cfg_data = '0;

    richardson_linear_solver DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the solver state
    logic signed [31:0] a_mat [N_ROWS*N_ROWS];
    logic signed [31:0] b_rhs [N_ENTRIES];
    logic signed [31:0] x_sol [N_ENTRIES];
    logic signed [31:0] r_res [N_ENTRIES];
    logic [7:0]         iter_limit = rls_pkg::LIMIT_RESET;
    logic [30:0]        tol_bound = rls_pkg::TOL_RESET;
    bit                 sat_seen;

    load_beat_t pending_beats [$];
    sol_beat_t  solution_q [$];

    int  errors = 0;
    int  solves = 0;
    int  beats_checked = 0;
    int  conv_count = 0;
    int  sat_count = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  stall_cycles = 0;
    bit  in_taken = 0;
    bit  tail = 0;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
        begin
            sat_seen = 1;
            return 32'h7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            sat_seen = 1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // Q16.16 product, round half up, floor shift
    function automatic longint qmul(logic signed [31:0] p, logic signed [31:0] q);
        longint prod;
        prod = longint'(p) * longint'(q) + 64'sd32768;
        return prod >>> 16;
    endfunction

    function automatic longint refresh_residual();
        longint peak;
        longint acc;
        longint mag;
        peak = 0;
        for (int r = 0; r < N_ROWS; r++)
            for (int c = 0; c < N_COLS; c++)
            begin
                acc = longint'(b_rhs[r*N_COLS + c]);
                for (int k = 0; k < N_ROWS; k++)
                    acc -= qmul(a_mat[r*N_ROWS + k], x_sol[k*N_COLS + c]);
                r_res[r*N_COLS + c] = sat32(acc);
                mag = longint'(r_res[r*N_COLS + c]);
                if (mag < 0) mag = -mag;
                if (mag > peak) peak = mag;
            end
        return peak;
    endfunction

    // Run one solve on the shadow state and queue the 64 solution beats
    task automatic predict_solve();
        longint norm;
        longint rowsum;
        longint e;
        longint peak;
        logic signed [31:0] omega;
        int done;
        bit conv;
        sol_beat_t s;
        sat_seen = 0;
        conv = 0;
        norm = 0;
        for (int r = 0; r < N_ROWS; r++)
        begin
            rowsum = 0;
            for (int k = 0; k < N_ROWS; k++)
            begin
                e = longint'(a_mat[r*N_ROWS + k]);
                if (e < 0) e = -e;
                if (e > 64'sd2147483647)
                begin
                    e = 64'sd2147483647;
                    sat_seen = 1;
                end
                rowsum += e;
                if (rowsum > 64'sd2147483647)
                begin
                    rowsum = 64'sd2147483647;
                    sat_seen = 1;
                end
            end
            if (rowsum > norm) norm = rowsum;
        end
        if (norm < 1) norm = 1;
        omega = sat32(64'sd4294967296 / norm);
        for (int n = 0; n < N_ENTRIES; n++)
            x_sol[n] = sat32(qmul(omega, b_rhs[n]));
        void'(refresh_residual());
        done = 0;
        while (done < iter_limit)
        begin
            peak = 0;
            for (int k = 0; k < rls_pkg::CHECK_PERIOD && done < iter_limit; k++)
            begin
                for (int n = 0; n < N_ENTRIES; n++)
                    x_sol[n] = sat32(longint'(x_sol[n]) + qmul(omega, r_res[n]));
                peak = refresh_residual();
                done++;
            end
            if (peak < longint'(tol_bound))
            begin
                conv = 1;
                break;
            end
        end
        for (int n = 0; n < N_ENTRIES; n++)
        begin
            s.row  = 4'(n / N_COLS);
            s.col  = 4'(n % N_COLS);
            s.x    = x_sol[n];
            s.conv = conv;
            s.sat  = sat_seen;
            s.last = (n == N_ENTRIES - 1);
            solution_q = {solution_q, s};
        end
        solves++;
        conv_count += conv;
        sat_count += sat_seen;
    endtask

    // Input side: mirror each accepted load beat, predict on a solve beat, schedule an idle burst now and then
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            in_taken = 1;
            if (mode == rls_pkg::MODE_A)
                a_mat[row*N_ROWS + col] = value;
            else if (mode == rls_pkg::MODE_B && col < N_COLS)
                b_rhs[row*N_COLS + col] = value;
            else if (mode == rls_pkg::MODE_SOLVE)
                predict_solve();
            if (!tail && $urandom_range(0, 3) == 0)
                in_gap = $urandom_range(1, 9);
        end
    end

    // Driver: advance to the next pending beat at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                load_beat_t b;
                b = pending_beats.pop_front();
                mode     <= b.mode;
                row      <= b.row;
                col      <= b.col;
                value    <= b.value;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver backpressure in bursts; none in the tail
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0 && !tail)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!tail && $urandom_range(0, 15) == 0)
                    out_gap = $urandom_range(1, 9);
            end
        end
    end

    // Monitor: compare each solution beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (solution_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected solution beat row %0d col %0d value %h",
                         $time, row_res, col_res, solution);
            end
            else
            begin
                sol_beat_t s;
                s = solution_q.pop_front();
                beats_checked++;
                if (row_res !== s.row || col_res !== s.col || solution !== s.x ||
                    converged !== s.conv || saturated !== s.sat || last !== s.last)
                begin
                    errors++;
                    $display("%0t: mismatch expected r%0d c%0d x=%h conv=%0b sat=%0b last=%0b",
                             $time, s.row, s.col, s.x, s.conv, s.sat, s.last);
                    $display("%0t:          actual   r%0d c%0d x=%h conv=%0b sat=%0b last=%0b",
                             $time, row_res, col_res, solution, converged, saturated, last);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("richardson_linear_solver regression: fail");
            $finish;
        end
    end

    task automatic queue_beat(logic [1:0] m, logic [3:0] r, logic [3:0] c, logic [31:0] v);
        load_beat_t b;
        b.mode = m;
        b.row = r;
        b.col = c;
        b.value = v;
        pending_beats = {pending_beats, b};
    endtask

    // Mostly a well-conditioned entry; sometimes any 32-bit pattern
    function automatic logic [31:0] pick_coeff(int r, int c, int wild_pct);
        if ($urandom_range(0, 99) < wild_pct)
            return $urandom;
        if (r == c)
            return 32'($urandom_range(65536, 131072));
        return 32'($urandom_range(0, 6554)) - 32'd3277;
    endfunction

    function automatic logic [31:0] pick_rhs(int wild_pct);
        if ($urandom_range(0, 99) < wild_pct)
            return $urandom;
        return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
    endfunction

    task automatic fill_all(int wild_pct);
        for (int r = 0; r < N_ROWS; r++)
            for (int c = 0; c < N_ROWS; c++)
                queue_beat(rls_pkg::MODE_A, 4'(r), 4'(c), pick_coeff(r, c, wild_pct));
        for (int r = 0; r < N_ROWS; r++)
            for (int c = 0; c < N_COLS; c++)
                queue_beat(rls_pkg::MODE_B, 4'(r), 4'(c), pick_rhs(wild_pct));
    endtask

    // Hold until every beat is sent and every solution returned, then let the block settle
    task automatic drain();
        while (pending_beats.size() > 0 || in_valid || solution_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [rls_pkg::CFG_IDX_W-1:0] idx,
                             logic [rls_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == rls_pkg::CFG_LIMIT)
            iter_limit = data[7:0];
        else
            tol_bound = data[30:0];
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: ignored beats, out-of-range rhs column, then a full fill
        // with extreme rhs values and a solve under reset settings
        queue_beat(MODE_UNUSED, 4'd15, 4'd15, 32'hFFFFFFFF);
        queue_beat(rls_pkg::MODE_B, 4'd15, 4'd15, 32'h80000000);
        queue_beat(rls_pkg::MODE_B, 4'd0, 4'd4, 32'h7FFFFFFF);
        fill_all(0);
        queue_beat(rls_pkg::MODE_B, 4'd0, 4'd0, 32'h7FFFFFFF);
        queue_beat(rls_pkg::MODE_B, 4'd15, 4'd3, 32'h80000000);
        queue_beat(rls_pkg::MODE_SOLVE, 4'd0, 4'd0, 32'h0);
        drain();

        // Zero limit and zero tolerance: start vector only
        write_reg(rls_pkg::CFG_LIMIT, 31'd0);
        write_reg(rls_pkg::CFG_TOL, 31'd0);
        queue_beat(rls_pkg::MODE_SOLVE, 4'd15, 4'd15, 32'hFFFFFFFF);
        drain();

        // Largest limit with the widest tolerance: stops at the first check
        write_reg(rls_pkg::CFG_LIMIT, 31'd255);
        write_reg(rls_pkg::CFG_TOL, 31'h7FFFFFFF);
        queue_beat(rls_pkg::MODE_B, 4'd0, 4'd0, 32'h00010000);
        queue_beat(rls_pkg::MODE_SOLVE, 4'd0, 4'd0, 32'h0);
        drain();

        // Extreme coefficients force saturation in the norm and the updates
        write_reg(rls_pkg::CFG_LIMIT, 31'd7);
        write_reg(rls_pkg::CFG_TOL, 31'd0);
        queue_beat(rls_pkg::MODE_A, 4'd3, 4'd3, 32'h80000000);
        queue_beat(rls_pkg::MODE_A, 4'd3, 4'd4, 32'h7FFFFFFF);
        queue_beat(rls_pkg::MODE_A, 4'd15, 4'd15, 32'h7FFFFFFF);
        queue_beat(rls_pkg::MODE_SOLVE, 4'd0, 4'd0, 32'h0);
        drain();

        // Random phases: sparse updates, noise, then a solve
        for (int ph = 0; ph < 7; ph++)
        begin
            int n_upd;
            write_reg(rls_pkg::CFG_LIMIT, 31'($urandom_range(1, 12)));
            case ($urandom_range(0, 2))
                0: write_reg(rls_pkg::CFG_TOL, 31'd0);
                1: write_reg(rls_pkg::CFG_TOL, 31'($urandom_range(1, 65536)));
                default: write_reg(rls_pkg::CFG_TOL, 31'($urandom));
            endcase
            n_upd = $urandom_range(10, 25);
            for (int i = 0; i < n_upd; i++)
            begin
                int r;
                int c;
                r = $urandom_range(0, 15);
                c = $urandom_range(0, 15);
                case ($urandom_range(0, 9))
                    0: queue_beat(MODE_UNUSED, 4'(r), 4'(c), $urandom);
                    1, 2, 3: queue_beat(rls_pkg::MODE_B, 4'(r), 4'(c), pick_rhs(10));
                    default: queue_beat(rls_pkg::MODE_A, 4'(r), 4'(c), pick_coeff(r, c, 5));
                endcase
            end
            if (ph == 6)
                tail = 1;
            queue_beat(rls_pkg::MODE_SOLVE, 4'($urandom), 4'($urandom), $urandom);
            drain();
        end

        repeat (20) @(posedge clk);
        if (solution_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d solution beats never arrived", $time, solution_q.size());
        end
        $display("covered %0d solves, %0d solution beats checked", solves, beats_checked);
        $display("%0d solves converged early, %0d saturated", conv_count, sat_count);
        if (errors == 0)
            $display("richardson_linear_solver regression: pass");
        else
            $display("richardson_linear_solver regression: fail");
        $finish;
    end

endmodule

// ===== richardson_linear_solver.f =====
sv/rls_pkg.sv
sv/rls_ram.sv
sv/rls_dp.sv
sv/rls_ctrl.sv
sv/richardson_linear_solver.sv
sv/rls_checker.sv
verif/tb.sv
